// ===== rtl/core/gbn_pkg.sv =====
// Shared types and constants for the go-back-n sender window.
// Event codes, timer codes and the controller/datapath interface structs.
// No dependencies.
package gbn_pkg;

    // Sequence number width (mod 8 numbering)
    localparam int SEQ_W = 3;

    // Event codes on s_cmd
    localparam logic [2:0] CMD_SEND    = 3'd0;
    localparam logic [2:0] CMD_TIMEOUT = 3'd1;
    localparam logic [2:0] CMD_WINDOW  = 3'd2;
    localparam logic [2:0] CMD_RR      = 3'd3;
    localparam logic [2:0] CMD_RNR     = 3'd4;

    // Timer action codes on m_timer_action
    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_RESTART = 2'd1;
    localparam logic [1:0] TMR_CANCEL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic exec_simple;  // run a single-result event straight off the input
        logic start_scan;   // latch ack target, clear walk index
        logic load_replay;  // load result register from queue entry at index
        logic idx_inc;      // advance walk index
        logic rr_finish;    // pop acknowledged entries, load RR result
    } gbn_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic fifo_empty;
        logic idx_last;     // walk index is on the youngest queued entry
        logic match;        // entry at walk index equals ack target
    } gbn_status_t;

endpackage

// ===== rtl/core/gbn_ctrl.sv =====
// Controller state machine for the go-back-n sender window.
// Sequences replay, ack search and result handshakes. Depends on gbn_pkg.
module gbn_ctrl import gbn_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    output logic        m_valid,
    input  logic        m_ready,
    input  gbn_status_t status,
    output gbn_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_REPLAY   = 5'b00010,
        ST_SEARCH   = 5'b00100,
        ST_EMIT     = 5'b01000,
        ST_EMIT_RPL = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT) || (state_reg == ST_EMIT_RPL);

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_TIMEOUT && !status.fifo_empty) begin
                        cmd.start_scan = 1'b1;
                        state_next     = ST_REPLAY;
                    end else if (s_cmd == CMD_RR && !status.fifo_empty) begin
                        cmd.start_scan = 1'b1;
                        state_next     = ST_SEARCH;
                    end else begin
                        cmd.exec_simple = 1'b1;
                        state_next      = ST_EMIT;
                    end
                end
            end
            ST_REPLAY: begin
                cmd.load_replay = 1'b1;
                state_next      = ST_EMIT_RPL;
            end
            ST_SEARCH: begin
                if (status.match || status.idx_last) begin
                    cmd.rr_finish = 1'b1;
                    state_next    = ST_EMIT;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_EMIT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RPL: begin
                if (m_ready) begin
                    if (status.idx_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_REPLAY;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/gbn_dp.sv =====
// Datapath for the go-back-n sender window: window state, pending queue,
// walk index and result register. Depends on gbn_pkg.
module gbn_dp import gbn_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [2:0]       s_cmd,
    input  logic [7:0]       s_window_size,
    input  logic [SEQ_W-1:0] s_ack_num,
    input  gbn_cmd_t         cmd,
    output gbn_status_t      status,
    output logic             m_send_valid,
    output logic [SEQ_W-1:0] m_seq_out,
    output logic [1:0]       m_timer_action,
    output logic             m_want_tick,
    output logic             m_last
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [7:0]       DEPTH_B = 8'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);

    // Pending queue storage
    logic [SEQ_W-1:0] fifo_mem [QUEUE_DEPTH];

    logic             send_en_reg, send_en_next;
    logic [CNT_W-1:0] win_reg, win_next;
    logic [SEQ_W-1:0] next_seq_reg, next_seq_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [SEQ_W-1:0] target_reg, target_next;

    logic             out_send_reg, out_send_next;
    logic [SEQ_W-1:0] out_seq_reg, out_seq_next;
    logic [1:0]       out_tmr_reg, out_tmr_next;
    logic             out_tick_reg, out_tick_next;
    logic             out_last_reg, out_last_next;

    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] rd_addr;
    logic [SEQ_W-1:0] rd_data_reg;
    logic [SUM_W-1:0] tail_sum, rd_sum, pop_sum;
    logic [CNT_W-1:0] npop, count_after_pop, idx_plus;

    // Circular address arithmetic: head plus offset wraps with one subtract.
    // Read address follows the next walk index so the registered entry
    // lines up with idx_reg.
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign rd_sum   = SUM_W'(head_reg) + SUM_W'(idx_next);
    assign pop_sum  = SUM_W'(head_reg) + SUM_W'(npop);
    assign wr_addr  = PTR_W'((tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum);
    assign rd_addr  = PTR_W'((rd_sum >= DEPTH_S) ? rd_sum - DEPTH_S : rd_sum);

    assign idx_plus = idx_reg + CNT_W'(1);

    // Ack search: pop through the matching entry, or everything if absent
    assign npop            = (rd_data_reg == target_reg) ? idx_plus : count_reg;
    assign count_after_pop = count_reg - npop;

    assign status.fifo_empty = (count_reg == '0);
    assign status.idx_last   = (idx_plus == count_reg);
    assign status.match      = (rd_data_reg == target_reg);

    // Next-state logic for window state, queue pointers and result register
    always_comb begin
        send_en_next  = send_en_reg;
        win_next      = win_reg;
        next_seq_next = next_seq_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        target_next   = target_reg;
        out_send_next = out_send_reg;
        out_seq_next  = out_seq_reg;
        out_tmr_next  = out_tmr_reg;
        out_tick_next = out_tick_reg;
        out_last_next = out_last_reg;
        wr_en         = 1'b0;

        if (cmd.exec_simple) begin
            out_send_next = 1'b0;
            out_seq_next  = '0;
            out_tmr_next  = TMR_NONE;
            out_tick_next = 1'b0;
            out_last_next = 1'b1;
            case (s_cmd)
                CMD_SEND: begin
                    if (send_en_reg && (count_reg < win_reg)) begin
                        wr_en         = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        next_seq_next = next_seq_reg + SEQ_W'(1);
                        out_send_next = 1'b1;
                        out_seq_next  = next_seq_reg;
                        out_tick_next = ((count_reg + CNT_W'(1)) < win_reg);
                    end
                end
                CMD_TIMEOUT: begin
                    // only reached with an empty queue
                    out_tmr_next = TMR_RESTART;
                end
                CMD_WINDOW: begin
                    win_next      = (s_window_size > DEPTH_B) ? DEPTH_C
                                                              : CNT_W'(s_window_size);
                    send_en_next  = 1'b1;
                    out_tmr_next  = TMR_CANCEL;
                    out_tick_next = 1'b1;
                end
                CMD_RR: begin
                    // only reached with an empty queue
                    send_en_next  = 1'b1;
                    out_tmr_next  = TMR_CANCEL;
                    out_tick_next = 1'b1;
                end
                CMD_RNR: begin
                    send_en_next = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (cmd.start_scan) begin
            idx_next    = '0;
            target_next = s_ack_num + SEQ_W'(1);
        end

        if (cmd.idx_inc) begin
            idx_next = idx_plus;
        end

        // Replay one queued entry
        if (cmd.load_replay) begin
            out_send_next = 1'b1;
            out_seq_next  = rd_data_reg;
            out_tmr_next  = status.idx_last ? TMR_RESTART : TMR_NONE;
            out_tick_next = 1'b0;
            out_last_next = status.idx_last;
        end

        // Retire acknowledged entries
        if (cmd.rr_finish) begin
            head_next     = PTR_W'((pop_sum >= DEPTH_S) ? pop_sum - DEPTH_S : pop_sum);
            count_next    = count_after_pop;
            send_en_next  = 1'b1;
            out_send_next = 1'b0;
            out_seq_next  = '0;
            out_tmr_next  = (count_after_pop == '0) ? TMR_CANCEL : TMR_RESTART;
            out_tick_next = 1'b1;
            out_last_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_en_reg  <= 1'b0;
            win_reg      <= '0;
            next_seq_reg <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
        end else begin
            send_en_reg  <= send_en_next;
            win_reg      <= win_next;
            next_seq_reg <= next_seq_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        target_reg   <= target_next;
        out_send_reg <= out_send_next;
        out_seq_reg  <= out_seq_next;
        out_tmr_reg  <= out_tmr_next;
        out_tick_reg <= out_tick_next;
        out_last_reg <= out_last_next;
    end

    // Queue write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fifo_mem[wr_addr] <= next_seq_reg;
        end
        rd_data_reg <= fifo_mem[rd_addr];
    end

    assign m_send_valid   = out_send_reg;
    assign m_seq_out      = out_seq_reg;
    assign m_timer_action = out_tmr_reg;
    assign m_want_tick    = out_tick_reg;
    assign m_last         = out_last_reg;

endmodule

// ===== rtl/core/go_back_n_sender_window.sv =====
// Top level of the go-back-n sender window (mod 8 sequence numbers).
// Joins gbn_ctrl and gbn_dp; depends on gbn_pkg.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+----------------------------------------
//  s_       | in        | s_valid / s_ready   | s_cmd, s_window_size, s_ack_num
//  m_       | out       | m_valid / m_ready   | m_send_valid, m_seq_out, m_timer_action,
//           |           |                     | m_want_tick, m_last
//
// One event at a time. Single-result events: the result is loaded on acceptance, then output from ST_EMIT.
// Timeout with N queued: each replayed entry goes through ST_REPLAY (queue read), then ST_EMIT_RPL (output).
// RR with N queued: ST_SEARCH steps through entries (up to N) until a match, then ST_EMIT outputs the result.
// The output register holds each result until m_ready; s_ready is low meanwhile.
// Reset (aresetn low, synchronous) empties the queue and disables sending.
module go_back_n_sender_window import gbn_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_cmd,
    input  logic [7:0]       s_window_size,
    input  logic [SEQ_W-1:0] s_ack_num,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_send_valid,
    output logic [SEQ_W-1:0] m_seq_out,
    output logic [1:0]       m_timer_action,
    output logic             m_want_tick,
    output logic             m_last
);

    gbn_cmd_t    cmd;
    gbn_status_t status;

    gbn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gbn_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_cmd          (s_cmd),
        .s_window_size  (s_window_size),
        .s_ack_num      (s_ack_num),
        .cmd            (cmd),
        .status         (status),
        .m_send_valid   (m_send_valid),
        .m_seq_out      (m_seq_out),
        .m_timer_action (m_timer_action),
        .m_want_tick    (m_want_tick),
        .m_last         (m_last)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the go-back-n sender window (mod 8 sequence numbers).
// Depends on gbn_pkg and go_back_n_sender_window; no other files.
module tb_top import gbn_pkg::*; ();

    localparam int QDEPTH = 8;
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int NUM_RANDOM = 400;

    typedef struct packed {
        logic       send_valid;
        logic [2:0] seq_out;
        logic [1:0] timer_action;
        logic       want_tick;
        logic       last;
    } tx_result_t;

    // Tracks window, enable and unacked queue; holds the outputs each event must produce
    class window_scoreboard;
        logic       send_en;
        logic [3:0] win_limit;
        logic [2:0] next_seq;
        logic [2:0] seq_ring [QDEPTH];
        logic [2:0] ring_head;
        logic [3:0] ring_count;
        tx_result_t due_outputs [$];
        int         errors;
        int         checked;

        function new();
            send_en    = 1'b0;
            win_limit  = '0;
            next_seq   = '0;
            ring_head  = '0;
            ring_count = '0;
            errors     = 0;
            checked    = 0;
            foreach (seq_ring[i]) seq_ring[i] = '0;
        endfunction

        function void add_due(logic sv, logic [2:0] seq, logic [1:0] tmr, logic tick,
                              logic lst);
            tx_result_t r;
            r.send_valid   = sv;
            r.seq_out      = seq;
            r.timer_action = tmr;
            r.want_tick    = tick;
            r.last         = lst;
            due_outputs.push_back(r);
        endfunction

        function int queued();
            return int'(ring_count);
        endfunction

        function logic [2:0] queued_at(int i);
            return seq_ring[(int'(ring_head) + i) % QDEPTH];
        endfunction

        function int outstanding();
            return due_outputs.size();
        endfunction

        // Update state for one accepted transaction and queue its outputs
        function void note_event(logic [2:0] cmd, logic [7:0] win, logic [2:0] ack);
            logic [2:0] target;
            int         npop;
            case (cmd)
                CMD_SEND: begin
                    if (send_en && ring_count < win_limit) begin
                        seq_ring[(int'(ring_head) + int'(ring_count)) % QDEPTH] = next_seq;
                        ring_count = ring_count + 4'd1;
                        add_due(1'b1, next_seq, TMR_NONE, ring_count < win_limit, 1'b1);
                        next_seq = next_seq + 3'd1;
                    end else begin
                        add_due(1'b0, 3'd0, TMR_NONE, 1'b0, 1'b1);
                    end
                end
                CMD_TIMEOUT: begin
                    if (ring_count == 0) begin
                        add_due(1'b0, 3'd0, TMR_RESTART, 1'b0, 1'b1);
                    end else begin
                        for (int i = 0; i < int'(ring_count); i++) begin
                            add_due(1'b1, queued_at(i),
                                    (i == int'(ring_count) - 1) ? TMR_RESTART : TMR_NONE,
                                    1'b0, i == int'(ring_count) - 1);
                        end
                    end
                end
                CMD_WINDOW: begin
                    win_limit = (win > QDEPTH) ? 4'(QDEPTH) : win[3:0];
                    send_en   = 1'b1;
                    add_due(1'b0, 3'd0, TMR_CANCEL, 1'b1, 1'b1);
                end
                CMD_RR: begin
                    // pop through the entry after the acked number, or flush if absent
                    target = ack + 3'd1;
                    npop   = int'(ring_count);
                    for (int i = 0; i < int'(ring_count); i++) begin
                        if (queued_at(i) == target && npop == int'(ring_count))
                            npop = i + 1;
                    end
                    ring_head  = 3'((int'(ring_head) + npop) % QDEPTH);
                    ring_count = ring_count - 4'(npop);
                    send_en    = 1'b1;
                    add_due(1'b0, 3'd0, (ring_count == 0) ? TMR_CANCEL : TMR_RESTART,
                            1'b1, 1'b1);
                end
                CMD_RNR: begin
                    send_en = 1'b0;
                    add_due(1'b0, 3'd0, TMR_NONE, 1'b0, 1'b1);
                end
                default: begin
                    add_due(1'b0, 3'd0, TMR_NONE, 1'b0, 1'b1);
                end
            endcase
        endfunction

        function void field_check(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $display("%0t: mismatch on %s, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one accepted output transaction with the oldest expectation
        function void check_result(tx_result_t got);
            tx_result_t want;
            if (due_outputs.size() == 0) begin
                $display("%0t: unexpected output, expected none, actual send=%0d seq=%0d",
                         $time, got.send_valid, got.seq_out);
                $display("      timer=%0d tick=%0d last=%0d",
                         got.timer_action, got.want_tick, got.last);
                errors++;
                return;
            end
            want = due_outputs.pop_front();
            checked++;
            field_check("send_valid", want.send_valid, got.send_valid);
            field_check("seq_out", want.seq_out, got.seq_out);
            field_check("timer_action", want.timer_action, got.timer_action);
            field_check("want_tick", want.want_tick, got.want_tick);
            field_check("last", want.last, got.last);
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_cmd = '0;
    logic [7:0] s_window_size = '0;
    logic [2:0] s_ack_num = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_send_valid;
    logic [2:0] m_seq_out;
    logic [1:0] m_timer_action;
    logic       m_want_tick;
    logic       m_last;

    window_scoreboard sb = new();
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold = 0;
    int cmd_seen [8];

    always #2 aclk = ~aclk;

    go_back_n_sender_window #(
        .QUEUE_DEPTH(QDEPTH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_window_size (s_window_size),
        .s_ack_num     (s_ack_num),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_send_valid  (m_send_valid),
        .m_seq_out     (m_seq_out),
        .m_timer_action(m_timer_action),
        .m_want_tick   (m_want_tick),
        .m_last        (m_last)
    );

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver backpressure
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 99) < 25)
                rx_hold = gap_len();
        end
    end

    // Monitor: inputs noted before outputs are checked on the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_event(s_cmd, s_window_size, s_ack_num);
                cmd_seen[s_cmd]++;
            end
            if (m_valid && m_ready)
                sb.check_result({m_send_valid, m_seq_out, m_timer_action, m_want_tick,
                                 m_last});
        end
    end

    // Present one transaction and hold it until accepted
    task automatic send_event(logic [2:0] cmd, logic [7:0] win, logic [2:0] ack);
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_window_size <= win;
        s_ack_num     <= ack;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Sender idle time between transactions
    task automatic maybe_pause();
        int n;
        if (tx_idle_on && $urandom_range(0, 99) < 40) begin
            n = gap_len();
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Hold off the sender until every queued output has come out
    task automatic drain_outputs();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    // Mostly protocol-like traffic: sends, acks of queued numbers, retries, window changes
    task automatic random_event();
        int         r;
        int         n;
        logic [2:0] cmd;
        logic [7:0] win;
        logic [2:0] ack;
        r   = $urandom_range(0, 99);
        win = 8'($urandom_range(0, 255));
        ack = 3'($urandom_range(0, 7));
        if (r < 55) begin
            cmd = CMD_SEND;
        end else if (r < 73) begin
            cmd = CMD_RR;
            n = sb.queued();
            if (n > 0 && $urandom_range(0, 99) < 80)
                ack = sb.queued_at(int'($urandom_range(0, n - 1))) - 3'd1;
        end else if (r < 83) begin
            cmd = CMD_TIMEOUT;
        end else if (r < 92) begin
            cmd = CMD_WINDOW;
            r = $urandom_range(0, 99);
            if (r < 60)
                win = 8'($urandom_range(1, QDEPTH));
            else if (r < 75)
                win = 8'd0;
        end else if (r < 96) begin
            cmd = CMD_RNR;
        end else begin
            cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        end
        send_event(cmd, win, ack);
    endtask

    initial begin
        int waited;
        int spare_seen;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: disabled sends, empty queue, spare codes, window extremes
        send_event(CMD_SEND, 8'hFF, 3'd7);
        send_event(CMD_TIMEOUT, 8'h00, 3'd0);
        send_event(CMD_RR, 8'h00, 3'd7);
        send_event(CMD_RNR, 8'hAA, 3'd5);
        send_event(CMD_SEND, 8'h55, 3'd2);
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            send_event(3'(c), 8'hFF, 3'd7);
        send_event(CMD_WINDOW, 8'd0, 3'd0);
        send_event(CMD_SEND, 8'd0, 3'd0);
        send_event(CMD_WINDOW, 8'd255, 3'd0);
        // fill the whole queue, then one send too many
        repeat (QDEPTH + 1) send_event(CMD_SEND, 8'd0, 3'd0);
        send_event(CMD_TIMEOUT, 8'd0, 3'd0);
        // ack a queued number, shrink the window below the queue, flush on absent ack
        send_event(CMD_RR, 8'd0, 3'd2);
        send_event(CMD_WINDOW, 8'd2, 3'd0);
        send_event(CMD_SEND, 8'd0, 3'd0);
        send_event(CMD_RR, 8'd0, 3'd0);
        drain_outputs();

        // Random traffic: idling, then back-to-back, then idling again
        for (int n = 0; n < NUM_RANDOM; n++) begin
            tx_idle_on = !(n >= 130 && n < 260);
            rx_idle_on = tx_idle_on;
            if (n == 100 || n == 200 || n == 330)
                drain_outputs();
            random_event();
            maybe_pause();
        end
        s_valid <= 1'b0;

        waited = 0;
        while (sb.outstanding() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (40) @(posedge aclk);
        if (sb.outstanding() != 0) begin
            $display("%0t: %0d expected outputs never arrived", $time, sb.outstanding());
            sb.errors++;
        end

        spare_seen = 0;
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            spare_seen += cmd_seen[c];

        $display("Covered %0d sends, %0d timeouts, %0d window replies, %0d RR, %0d RNR,",
                 cmd_seen[CMD_SEND], cmd_seen[CMD_TIMEOUT], cmd_seen[CMD_WINDOW],
                 cmd_seen[CMD_RR], cmd_seen[CMD_RNR]);
        $display("  %0d spare codes; %0d outputs checked, %0d errors",
                 spare_seen, sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
